// ----- src/scd_pkg.sv -----
// ----------------------------------------------------------------------------
// scd_pkg: shared constants, types and helpers
// Sizes, reset values, register indexes and controller/datapath structs
// for the stereo cross delay mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package scd_pkg;

   localparam int DELAY_DEPTH = 512;
   localparam int PTR_BITS    = $clog2(DELAY_DEPTH);
   localparam int SAMPLE_BITS = 24;
   localparam int DEPTH_BITS  = 16;
   localparam int TAPS_BITS   = 9;
   localparam int SMOOTH_BITS = 32;
   localparam int CSR_BITS    = 16;
   localparam int CSR_IDX_BITS = 1;

   // one-pole smoothing coefficient, 131/65536
   localparam int COEF_BITS   = 8;
   localparam int COEF_SHIFT  = 16;
   localparam logic [COEF_BITS-1:0] SMOOTH_COEF = COEF_BITS'(131);

   // diff of two unsigned Q0.32 values, signed
   localparam int DIFF_BITS = SMOOTH_BITS + 2;
   localparam int STEP_BITS = DIFF_BITS + COEF_BITS + 1 - COEF_SHIFT;
   localparam int PROD_BITS = SAMPLE_BITS + SMOOTH_BITS + 1;
   localparam int WET_BITS  = PROD_BITS - SMOOTH_BITS;
   localparam int SUM_BITS  = SAMPLE_BITS + 2;

   localparam logic [DEPTH_BITS-1:0]  DEPTH_RESET  = DEPTH_BITS'(16384);
   localparam logic [TAPS_BITS-1:0]   TAPS_RESET   = TAPS_BITS'(48);
   localparam logic [SMOOTH_BITS-1:0] SMOOTH_RESET = SMOOTH_BITS'(32'h4000_0000);

   localparam logic [CSR_IDX_BITS-1:0] REG_DEPTH      = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] REG_DELAY_TAPS = CSR_IDX_BITS'(1);

   typedef struct packed {
      logic accept;    // latch frame, write and read the delay stores
      logic smooth;    // apply the smoothing step
      logic mul_r;     // multiply delayed right by depth
      logic mul_l;     // finish left, multiply delayed left by depth
      logic load_out;  // finish right, load the output register
   } cmd_type;

   typedef struct packed {
      logic out_free;  // output register empty or being taken
   } status_type;

   function automatic logic signed [SAMPLE_BITS-1:0] saturate(
      input logic signed [SUM_BITS-1:0] v
   );
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      hi = SUM_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
      lo = -hi - SUM_BITS'(1);
      if (v > hi) begin
         return hi[SAMPLE_BITS-1:0];
      end else if (v < lo) begin
         return lo[SAMPLE_BITS-1:0];
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/scd_ctrl.sv -----
// ----------------------------------------------------------------------------
// scd_ctrl: frame sequencer
// Steps one frame through smoothing, two shared multiplies and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire scd_pkg::status_type status,
   output scd_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SMOOTH,
      S_MUL_R,
      S_MUL_L,
      S_DONE
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE:   if (req_tvalid) state_ff <= S_SMOOTH;
            S_SMOOTH: state_ff <= S_MUL_R;
            S_MUL_R:  state_ff <= S_MUL_L;
            S_MUL_L:  state_ff <= S_DONE;
            S_DONE:   if (status.out_free) state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready   = (state_ff == S_IDLE);
   assign cmd.accept   = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.smooth   = (state_ff == S_SMOOTH);
   assign cmd.mul_r    = (state_ff == S_MUL_R);
   assign cmd.mul_l    = (state_ff == S_MUL_L);
   assign cmd.load_out = (state_ff == S_DONE) && status.out_free;

endmodule

`default_nettype wire

// ----- src/scd_datapath.sv -----
// ----------------------------------------------------------------------------
// scd_datapath: delay stores, depth smoothing and cross-mix arithmetic
// One shared signed multiplier, registered product, saturating output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module scd_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire scd_pkg::cmd_type                       cmd,
   output scd_pkg::status_type                         status,
   input  wire logic [scd_pkg::SAMPLE_BITS-1:0]        req_left,
   input  wire logic [scd_pkg::SAMPLE_BITS-1:0]        req_right,
   input  wire logic                                   req_last,
   input  wire logic [scd_pkg::DEPTH_BITS-1:0]         cfg_depth,
   input  wire logic [scd_pkg::TAPS_BITS-1:0]          cfg_taps,
   output logic [scd_pkg::SAMPLE_BITS-1:0]             rsp_left,
   output logic [scd_pkg::SAMPLE_BITS-1:0]             rsp_right,
   output logic                                        rsp_last,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready
);

   localparam int SB = scd_pkg::SAMPLE_BITS;
   localparam int PB = scd_pkg::PTR_BITS;

   logic [SB-1:0] left_mem  [scd_pkg::DELAY_DEPTH];
   logic [SB-1:0] right_mem [scd_pkg::DELAY_DEPTH];

   logic [PB-1:0] wp_ff;
   logic          wrapped_ff;
   logic [PB-1:0] rp;

   logic [SB-1:0] rd_l_ff, rd_r_ff;
   logic          rd_ok_ff;
   logic [SB-1:0] in_l_ff, in_r_ff;
   logic          last_ff;

   logic [scd_pkg::SMOOTH_BITS-1:0]       smoothed_ff;
   logic signed [scd_pkg::STEP_BITS-1:0]  step_ff;
   logic signed [scd_pkg::DIFF_BITS-1:0]  diff;
   logic signed [scd_pkg::DIFF_BITS+scd_pkg::COEF_BITS:0] scaled;

   logic signed [SB-1:0]                  mul_a;
   logic signed [scd_pkg::SMOOTH_BITS:0]  mul_b;
   logic signed [scd_pkg::PROD_BITS-1:0]  prod_ff;
   logic signed [scd_pkg::WET_BITS-1:0]   wet;
   logic signed [SB-1:0]                  mix_in;
   logic signed [scd_pkg::SUM_BITS-1:0]   sum;
   logic signed [SB-1:0]                  sat_val;
   logic [SB-1:0]                         res_l_ff;

   // modulo-depth read position, wraps naturally in the pointer width
   assign rp = wp_ff - PB'(cfg_taps);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         left_mem[wp_ff]  <= req_left;
         right_mem[wp_ff] <= req_right;
         rd_l_ff          <= left_mem[rp];
         rd_r_ff          <= right_mem[rp];
      end
   end

   // one-pole step from the current target
   assign diff   = $signed({2'b00, cfg_depth, 16'h0000}) -
                   $signed({2'b00, smoothed_ff});
   assign scaled = diff * $signed({1'b0, scd_pkg::SMOOTH_COEF});

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         wrapped_ff  <= 1'b0;
         smoothed_ff <= scd_pkg::SMOOTH_RESET;
      end else begin
         if (cmd.accept) begin
            wp_ff <= wp_ff + PB'(1);
            if (wp_ff == PB'(scd_pkg::DELAY_DEPTH - 1)) wrapped_ff <= 1'b1;
         end
         if (cmd.smooth) begin
            smoothed_ff <= smoothed_ff +
                           scd_pkg::SMOOTH_BITS'(unsigned'(
                              {{(scd_pkg::SMOOTH_BITS + 1 - scd_pkg::STEP_BITS)
                                {step_ff[scd_pkg::STEP_BITS-1]}}, step_ff}));
         end
      end
   end

   // frame latch; an entry never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         in_l_ff  <= req_left;
         in_r_ff  <= req_right;
         last_ff  <= req_last;
         rd_ok_ff <= wrapped_ff || (rp < wp_ff);
         step_ff  <= scd_pkg::STEP_BITS'(scaled >>> scd_pkg::COEF_SHIFT);
      end
   end

   // shared multiplier: right tap first, then left tap
   assign mul_a = rd_ok_ff ? $signed(cmd.mul_r ? rd_r_ff : rd_l_ff) : '0;
   assign mul_b = $signed({1'b0, smoothed_ff});

   always_ff @(posedge clock) begin
      if (cmd.mul_r || cmd.mul_l) begin
         prod_ff <= scd_pkg::PROD_BITS'(mul_a * mul_b);
      end
   end

   assign wet     = prod_ff[scd_pkg::PROD_BITS-1:scd_pkg::SMOOTH_BITS];
   assign mix_in  = $signed(cmd.mul_l ? in_l_ff : in_r_ff);
   assign sum     = scd_pkg::SUM_BITS'(mix_in) + scd_pkg::SUM_BITS'(wet);
   assign sat_val = scd_pkg::saturate(sum);

   always_ff @(posedge clock) begin
      if (cmd.mul_l) res_l_ff <= sat_val;
      if (cmd.load_out) begin
         rsp_left  <= res_l_ff;
         rsp_right <= sat_val;
         rsp_last  <= last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   assign status.out_free = !rsp_valid || rsp_ready;

endmodule

`default_nettype wire

// ----- src/stereo_cross_delay_mixer.sv -----
// ----------------------------------------------------------------------------
// stereo_cross_delay_mixer: stereo cross-feed delay
// Each output channel is its own input plus the other channel's delayed
// sample scaled by a smoothed mix depth, saturated to 24 bits.
//
// channels: req_ carries one stereo frame per beat, rsp_ one mixed frame per
// beat, tlast passes the block end marker through. csr_ writes the depth
// (index 0, Q0.16) and the tap delay (index 1, frames); the user must write
// them only while the block idles, which the block itself does not enforce.
// sequencing: a new frame is taken only after the sequencer has stepped one
// shared 24x33 multiplier through both channels after the smoothing step.
// req_tready is high only while the sequencer waits for a frame; a new frame
// is taken while an earlier result still sits in the output register.
// stall: with rsp_tready low the finished frame holds in the output register
// and the next frame waits in the final step until that beat is taken.
// reset: synchronous, clears pointer, fill tracking and handshakes, loads the
// register defaults; the delay stores are not swept, entries never written
// since reset read as zero through a wrap flag.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_cross_delay_mixer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // input frame stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [2*scd_pkg::SAMPLE_BITS-1:0]   req_tdata,  // left_sample, right_sample
   input  wire logic                                req_tlast,  // block_end
   // mixed frame stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [2*scd_pkg::SAMPLE_BITS-1:0]        rsp_tdata,  // left_out, right_out
   output logic                                     rsp_tlast,  // block_end_out
   // register writes
   input  wire logic                                csr_we,
   input  wire logic [scd_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  wire logic [scd_pkg::CSR_BITS-1:0]        csr_wdata
);

   localparam int SB = scd_pkg::SAMPLE_BITS;

   logic [scd_pkg::DEPTH_BITS-1:0] depth_ff;
   logic [scd_pkg::TAPS_BITS-1:0]  taps_ff;

   scd_pkg::cmd_type    cmd;
   scd_pkg::status_type status;

   logic [SB-1:0] rsp_left, rsp_right;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= scd_pkg::DEPTH_RESET;
         taps_ff  <= scd_pkg::TAPS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            scd_pkg::REG_DEPTH:      depth_ff <= csr_wdata[scd_pkg::DEPTH_BITS-1:0];
            scd_pkg::REG_DELAY_TAPS: taps_ff  <= csr_wdata[scd_pkg::TAPS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   scd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // delay stores and arithmetic
   scd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_left  (req_tdata[SB-1:0]),
      .req_right (req_tdata[2*SB-1:SB]),
      .req_last  (req_tlast),
      .cfg_depth (depth_ff),
      .cfg_taps  (taps_ff),
      .rsp_left  (rsp_left),
      .rsp_right (rsp_right),
      .rsp_last  (rsp_tlast),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {rsp_right, rsp_left};

   // one frame in flight: input closes right after a beat is taken
   a_single_frame: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted twice for one frame");

   // sequencer issues at most one step per cycle
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.accept, cmd.smooth, cmd.mul_r, cmd.mul_l, cmd.load_out}))
      else $error("overlapping datapath steps");

   // never overwrite a result the receiver has not taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && rsp_tvalid) |-> rsp_tready)
      else $error("output register overwritten while stalled");

   // a result appears only from the output load step
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(cmd.load_out))
      else $error("result valid without a load step");

endmodule

`default_nettype wire
